@@ rtl/two_level_page_map_with_frame_bitmap_core_macros.svh @@
// Assertion macros used by the checker.
`ifndef TWO_LEVEL_PAGE_MAP_WITH_FRAME_BITMAP_CORE_MACROS_SVH
`define TWO_LEVEL_PAGE_MAP_WITH_FRAME_BITMAP_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TLPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define TLPM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/tlpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types and constants of the two-level page map core.
// ----------------------------------------------------------------------------
package tlpm_pkg;
   localparam int NumFrames     = 256;
   localparam int WordsPerFrame = 1024;
   localparam int FrameW        = $clog2(NumFrames);
   localparam int FrameCntW     = FrameW + 1;
   localparam int WordAddrW     = FrameW + 10;
   localparam int StoreWords    = NumFrames * WordsPerFrame;

   localparam logic [31:0] PageMask = 32'hffff_f000;
   localparam logic [31:0] OfsMask  = 32'h0000_0fff;
   localparam logic [31:0] ValidBit = 32'h0000_0001;

   typedef enum logic [2:0] {
      OP_TRANSLATE = 3'd0,
      OP_MAP       = 3'd1,
      OP_UNMAP     = 3'd2,
      OP_ALLOC     = 3'd3,
      OP_FREE      = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FRAME = 2'd1,
      ST_NO_TABLE = 2'd2,
      ST_OUTSIDE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_ROOT  = 2'd0,
      CSR_BASE  = 2'd1,
      CSR_FIRST = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIR_RD, S_DIR_CHK, S_SEARCH, S_TAB_RD, S_TAB_CHK,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;    // write zero at clear pointer
      logic load;        // capture request
      logic dir_rd;      // issue directory read
      logic tab_rd;      // issue table read
      logic search_start;
      logic search_step;
      logic commit_new;  // write new directory entry, mark frame
      logic alloc_done;  // record alloc result, mark frame
      logic tab_wr;      // write table entry per op
      logic free_do;
      logic set_status;
      status_type status;
      logic respond;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       clr_last;
      logic       root_bad;
      logic       dir_empty;
      logic       tab_bad;
      logic       search_found;
      logic       search_end;
      op_type     op;
   } stat_type;
endpackage

@@ rtl/tlpm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_ctrl
// Sequencer for store clear, table walk and frame search.
// ----------------------------------------------------------------------------
module tlpm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tlpm_pkg::stat_type stat,
   output tlpm_pkg::cmd_type  cmd
);
   tlpm_pkg::state_type state_ff, state_in;
   logic alloc_ff, alloc_in;   // search is for explicit alloc op

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpm_pkg::S_CLEAR;
         alloc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         alloc_ff <= alloc_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      alloc_in = alloc_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         tlpm_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = tlpm_pkg::S_IDLE;
         end
         tlpm_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = tlpm_pkg::S_DIR_RD;
            end
         end
         tlpm_pkg::S_DIR_RD: begin
            cmd.set_status = 1'b1;
            cmd.status     = tlpm_pkg::ST_OK;
            unique case (stat.op)
               tlpm_pkg::OP_TRANSLATE, tlpm_pkg::OP_MAP, tlpm_pkg::OP_UNMAP: begin
                  if (stat.root_bad) begin
                     cmd.status = tlpm_pkg::ST_OUTSIDE;
                     state_in   = tlpm_pkg::S_DONE;
                  end else begin
                     cmd.dir_rd = 1'b1;
                     state_in   = tlpm_pkg::S_DIR_CHK;
                  end
               end
               tlpm_pkg::OP_ALLOC: begin
                  cmd.search_start = 1'b1;
                  alloc_in = 1'b1;
                  state_in = tlpm_pkg::S_SEARCH;
               end
               tlpm_pkg::OP_FREE: begin
                  cmd.free_do = 1'b1;
                  state_in = tlpm_pkg::S_DONE;
               end
               default: state_in = tlpm_pkg::S_DONE;
            endcase
         end
         tlpm_pkg::S_DIR_CHK: begin
            if (stat.dir_empty) begin
               if (stat.op == tlpm_pkg::OP_MAP) begin
                  cmd.search_start = 1'b1;
                  alloc_in = 1'b0;
                  state_in = tlpm_pkg::S_SEARCH;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = tlpm_pkg::ST_NO_TABLE;
                  state_in       = tlpm_pkg::S_DONE;
               end
            end else begin
               state_in = tlpm_pkg::S_TAB_RD;
            end
         end
         tlpm_pkg::S_SEARCH: begin
            if (stat.search_found) begin
               if (alloc_ff) begin
                  cmd.alloc_done = 1'b1;
                  state_in = tlpm_pkg::S_DONE;
               end else begin
                  cmd.commit_new = 1'b1;
                  state_in = tlpm_pkg::S_TAB_RD;
               end
            end else if (stat.search_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = tlpm_pkg::ST_NO_FRAME;
               state_in       = tlpm_pkg::S_DONE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         tlpm_pkg::S_TAB_RD: begin
            if (stat.tab_bad) begin
               cmd.set_status = 1'b1;
               cmd.status     = tlpm_pkg::ST_OUTSIDE;
               state_in       = tlpm_pkg::S_DONE;
            end else begin
               cmd.tab_rd = 1'b1;
               state_in   = tlpm_pkg::S_TAB_CHK;
            end
         end
         tlpm_pkg::S_TAB_CHK: begin
            cmd.tab_wr = 1'b1;
            state_in   = tlpm_pkg::S_DONE;
         end
         tlpm_pkg::S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = tlpm_pkg::S_IDLE;
         end
         default: state_in = tlpm_pkg::S_IDLE;
      endcase
   end
endmodule

@@ rtl/tlpm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_datapath
// Page store, frame bitmap, config registers and result registers.
// ----------------------------------------------------------------------------
module tlpm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tlpm_pkg::cmd_type                    cmd,
   output tlpm_pkg::stat_type                   stat,
   input  logic                                 csr_valid,
   input  logic [1:0]                           csr_index,
   input  logic [31:0]                          csr_data,
   input  logic [2:0]                           req_operation,
   input  logic [31:0]                          req_virt_addr,
   input  logic [31:0]                          req_phys_addr,
   input  logic [7:0]                           req_frame_index,
   output logic                                 rsp_valid,
   output logic [31:0]                          rsp_phys_result,
   output logic [7:0]                           rsp_frame_number,
   output logic [1:0]                           rsp_status
);
   localparam int FW  = tlpm_pkg::FrameW;
   localparam int FCW = tlpm_pkg::FrameCntW;
   localparam int AW  = tlpm_pkg::WordAddrW;

   logic [31:0] store [tlpm_pkg::StoreWords];
   logic [31:0] rd_ff;
   logic [tlpm_pkg::NumFrames-1:0] used_ff;

   logic [7:0]  root_ff;
   logic [31:0] base_ff;
   logic [8:0]  first_ff;

   logic [2:0]  op_ff;
   logic [31:0] va_ff, pa_ff;
   logic [7:0]  fi_ff;
   logic [AW-1:0]  clr_ff, dpos_ff;
   logic [31:0] taddr_ff;
   logic [FCW-1:0] scan_ff;
   logic [1:0]  status_ff;
   logic [7:0]  fnum_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_phys_ff;

   logic [31:0]    toff, new_ta;
   logic [AW-1:0]  tpos;
   logic           we;
   logic [AW-1:0]  waddr, raddr;
   logic [31:0]    wdata;

   always_comb begin
      toff   = taddr_ff - base_ff;
      tpos   = {toff[FW+11:12], va_ff[21:12]};
      new_ta = {{(20-FW){1'b0}}, scan_ff[FW-1:0], 12'h000} + base_ff;
      stat.clr_last  = (clr_ff == AW'(tlpm_pkg::StoreWords - 1));
      stat.root_bad  = ({24'd0, root_ff} >= 32'(tlpm_pkg::NumFrames));
      stat.dir_empty = ((rd_ff & tlpm_pkg::PageMask) == 32'd0);
      stat.tab_bad   = (toff >= 32'(tlpm_pkg::NumFrames * 4096));
      stat.search_end   = (scan_ff >= FCW'(tlpm_pkg::NumFrames));
      stat.search_found = !stat.search_end && !used_ff[scan_ff[FW-1:0]];
      stat.op = tlpm_pkg::op_type'(op_ff);

      we = 1'b0; waddr = dpos_ff; wdata = 32'd0;
      if (cmd.clr_step) begin
         we = 1'b1; waddr = clr_ff;
      end else if (cmd.commit_new) begin
         we = 1'b1; waddr = dpos_ff; wdata = new_ta | tlpm_pkg::ValidBit;
      end else if (cmd.tab_wr) begin
         waddr = tpos;
         if (op_ff == tlpm_pkg::OP_MAP) begin
            we = (rd_ff == 32'd0); wdata = pa_ff | tlpm_pkg::ValidBit;
         end else if (op_ff == tlpm_pkg::OP_UNMAP) begin
            we = 1'b1;
         end
      end
      raddr = cmd.tab_rd ? tpos : dpos_ff;
   end

   always_ff @(posedge clock) begin
      if (we) store[waddr] <= wdata;
      if (cmd.dir_rd || cmd.tab_rd) rd_ff <= store[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff  <= 8'd0;
         base_ff  <= 32'h8000_0000;
         first_ff <= 9'd64;
         used_ff  <= '0;
         clr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.clr_step) clr_ff <= clr_ff + AW'(1);
         if (csr_valid) begin
            case (csr_index)
               tlpm_pkg::CSR_ROOT:  root_ff  <= csr_data[7:0];
               tlpm_pkg::CSR_BASE:  base_ff  <= csr_data;
               tlpm_pkg::CSR_FIRST: first_ff <= csr_data[8:0];
               default: ;
            endcase
         end
         if (cmd.commit_new || cmd.alloc_done) used_ff[scan_ff[FW-1:0]] <= 1'b1;
         if (cmd.free_do && ({1'b0, fi_ff} < 9'(tlpm_pkg::NumFrames)))
            used_ff[fi_ff[FW-1:0]] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         va_ff <= req_virt_addr;
         pa_ff <= req_phys_addr;
         fi_ff <= req_frame_index;
         fnum_ff <= 8'd0;
         rsp_phys_ff <= 32'd0;
         // directory word address, ready for the read in the next cycle
         dpos_ff <= {root_ff[FW-1:0], req_virt_addr[31:22]};
      end
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.search_start) scan_ff <= FCW'(first_ff);
      if (cmd.search_step) scan_ff <= scan_ff + FCW'(1);
      if (cmd.commit_new) taddr_ff <= new_ta & tlpm_pkg::PageMask;
      else if (!cmd.tab_wr && !cmd.tab_rd && !cmd.search_step && !cmd.load)
         taddr_ff <= rd_ff & tlpm_pkg::PageMask;
      if (cmd.alloc_done) fnum_ff <= 8'(scan_ff);
      if (cmd.tab_wr && op_ff == tlpm_pkg::OP_TRANSLATE)
         rsp_phys_ff <= (rd_ff & tlpm_pkg::PageMask) | (va_ff & tlpm_pkg::OfsMask);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phys_result  = rsp_phys_ff;
   assign rsp_frame_number = fnum_ff;
   assign rsp_status       = status_ff;
endmodule

@@ rtl/two_level_page_map_with_frame_bitmap_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_map_with_frame_bitmap_core
// Two-level page table walker with frame allocation bitmap.
// ----------------------------------------------------------------------------
// After reset the page store is cleared one word a cycle (busy high).
// A full walk does a directory read, a table read and a table write, in
// that order. Free and unused codes skip the walk, and a request whose
// table is missing ends after the directory read. A bitmap search, for an
// allocate request or a map that needs a new table, examines the entries
// in turn from first_user_frame and ends with no-frame when none is free.
// The result is shown for one cycle on rsp_valid and cannot be stalled.
// Config writes are always taken.
module two_level_page_map_with_frame_bitmap_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr,
   input  logic [7:0]  req_frame_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_phys_result,
   output logic [7:0]  rsp_frame_number,
   output logic [1:0]  rsp_status
);
   tlpm_pkg::cmd_type  cmd;
   tlpm_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   tlpm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   tlpm_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_operation(req_operation), .req_virt_addr(req_virt_addr),
      .req_phys_addr(req_phys_addr), .req_frame_index(req_frame_index),
      .rsp_valid(rsp_valid), .rsp_phys_result(rsp_phys_result),
      .rsp_frame_number(rsp_frame_number), .rsp_status(rsp_status)
   );
endmodule

@@ rtl/tlpm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_checker
// Port-level checks of the page map core.
// ----------------------------------------------------------------------------
`include "two_level_page_map_with_frame_bitmap_core_macros.svh"
module tlpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_frame_number,
   input logic [1:0]  rsp_status
);
   `TLPM_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "busy not raised")
   `TLPM_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, !busy, "strobe while busy")
   `TLPM_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "double strobe")
   `TLPM_ASSERT_IMP(a_nofr, clock, reset, rsp_valid && rsp_status == tlpm_pkg::ST_NO_FRAME, rsp_frame_number == 8'd0, "frame on failure")
endmodule

bind two_level_page_map_with_frame_bitmap_core tlpm_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_frame_number(rsp_frame_number),
   .rsp_status(rsp_status)
);

@@ dv/two_level_page_map_with_frame_bitmap_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_map_with_frame_bitmap_core_test
// Self-checking bench for the two-level page map core. A directed table
// runs after reset. Random words follow in several register settings. Each
// response word is checked against its directed row, or else against a
// software copy of the directory, page tables and frame bitmap.
// ----------------------------------------------------------------------------
module two_level_page_map_with_frame_bitmap_core_test;

   localparam int IdleLimit = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [31:0] req_virt_addr = '0;
   logic [31:0] req_phys_addr = '0;
   logic [7:0]  req_frame_index = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        rsp_valid;
   logic [31:0] rsp_phys_result;
   logic [7:0]  rsp_frame_number;
   logic [1:0]  rsp_status;

   two_level_page_map_with_frame_bitmap_core uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   typedef struct {
      logic [31:0]          phys;
      logic [7:0]           fnum;
      tlpm_pkg::status_type status;
   } walk_result_type;

   typedef struct {
      logic [2:0]           op;
      logic [31:0]          va;
      logic [31:0]          pa;
      logic [7:0]           fi;
      bit                   typed;
      logic [31:0]          phys;
      logic [7:0]           fnum;
      tlpm_pkg::status_type status;
   } table_row_type;

   // shadow of the block
   bit [31:0]   store_words[int];
   bit          frame_busy[tlpm_pkg::NumFrames];
   logic [7:0]  root_frame;
   logic [31:0] ram_base;
   logic [8:0]  first_frame;

   walk_result_type walk_q[$];
   int  mismatches = 0;
   bit  failed = 1'b0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;
   logic [31:0] va_pool[$];

   function automatic int take_frame();
      for (int f = first_frame; f < tlpm_pkg::NumFrames; f++)
         if (!frame_busy[f]) begin
            frame_busy[f] = 1'b1;
            return f;
         end
      return -1;
   endfunction

   function automatic int frame_at(logic [31:0] addr);
      logic [31:0] off;
      off = addr - ram_base;
      if (off >= tlpm_pkg::NumFrames * 4096) return -1;
      return int'(off >> 12);
   endfunction

   function automatic walk_result_type walk(logic [2:0] op, logic [31:0] va,
                                            logic [31:0] pa, logic [7:0] fi);
      walk_result_type r;
      int dpos, tpos, nf, tf;
      logic [31:0] taddr;
      bit ok;
      r.phys = '0; r.fnum = '0; r.status = tlpm_pkg::ST_OK;
      if (op == tlpm_pkg::OP_TRANSLATE || op == tlpm_pkg::OP_MAP ||
          op == tlpm_pkg::OP_UNMAP) begin
         dpos = int'(root_frame) * tlpm_pkg::WordsPerFrame + int'(va[31:22]);
         taddr = store_words[dpos] & tlpm_pkg::PageMask;
         ok = 1'b1;
         if (taddr == 0) begin
            if (op == tlpm_pkg::OP_MAP) begin
               nf = take_frame();
               if (nf < 0) begin
                  r.status = tlpm_pkg::ST_NO_FRAME; ok = 1'b0;
               end else begin
                  store_words[dpos] = ((32'(nf) << 12) + ram_base) | tlpm_pkg::ValidBit;
                  taddr = store_words[dpos] & tlpm_pkg::PageMask;
               end
            end else begin
               r.status = tlpm_pkg::ST_NO_TABLE; ok = 1'b0;
            end
         end
         if (ok) begin
            tf = frame_at(taddr);
            if (tf < 0) r.status = tlpm_pkg::ST_OUTSIDE;
            else begin
               tpos = tf * tlpm_pkg::WordsPerFrame + int'(va[21:12]);
               if (op == tlpm_pkg::OP_TRANSLATE)
                  r.phys = (store_words[tpos] & tlpm_pkg::PageMask) |
                           (va & tlpm_pkg::OfsMask);
               else if (op == tlpm_pkg::OP_MAP) begin
                  if (store_words[tpos] == 0) store_words[tpos] = pa | tlpm_pkg::ValidBit;
               end else
                  store_words[tpos] = '0;
            end
         end
      end else if (op == tlpm_pkg::OP_ALLOC) begin
         nf = take_frame();
         if (nf < 0) r.status = tlpm_pkg::ST_NO_FRAME;
         else r.fnum = nf[7:0];
      end else if (op == tlpm_pkg::OP_FREE) begin
         frame_busy[fi] = 1'b0;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic [2:0] op, logic [31:0] va, logic [31:0] pa,
                       logic [7:0] fi, bit typed, walk_result_type typed_res);
      walk_result_type r;
      int gap;
      @(negedge clock);
      req_operation <= op;
      req_virt_addr <= va;
      req_phys_addr <= pa;
      req_frame_index <= fi;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      r = walk(op, va, pa, fi);
      walk_q.push_back(typed ? typed_res : r);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_rand(logic [2:0] op, logic [31:0] va, logic [31:0] pa,
                            logic [7:0] fi);
      walk_result_type none;
      none.phys = '0;
      none.fnum = '0;
      none.status = tlpm_pkg::ST_OK;
      send(op, va, pa, fi, 1'b0, none);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tlpm_pkg::CSR_ROOT:  root_frame = data[7:0];
         tlpm_pkg::CSR_BASE:  ram_base = data;
         tlpm_pkg::CSR_FIRST: first_frame = data[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (walk_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      walk_result_type e;
      if (!reset && rsp_valid) begin
         if (walk_q.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word");
         end else begin
            e = walk_q.pop_front();
            if (rsp_phys_result !== e.phys || rsp_frame_number !== e.fnum ||
                rsp_status !== e.status) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp phys %h fnum %h st %0d, got %h %h %0d",
                           e.phys, e.fnum, e.status, rsp_phys_result,
                           rsp_frame_number, rsp_status);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("[two_level_page_map_with_frame_bitmap_core] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   table_row_type rows[$];

   task automatic add_row(logic [2:0] op, logic [31:0] va, logic [31:0] pa,
                          logic [7:0] fi, bit typed, logic [31:0] phys,
                          logic [7:0] fnum, tlpm_pkg::status_type st);
      table_row_type t;
      t = '{op, va, pa, fi, typed, phys, fnum, st};
      rows.push_back(t);
   endtask

   function automatic logic [31:0] pool_va();
      if (va_pool.size() == 0) return $urandom();
      return {va_pool[$urandom_range(0, va_pool.size() - 1)][31:12],
              12'($urandom())};
   endfunction

   function automatic logic [31:0] fresh_va();
      logic [9:0] d;
      case ($urandom_range(0, 4))
         0: d = 10'd0;
         1: d = 10'd1;
         2: d = 10'h3ff;
         3: d = 10'($urandom_range(2, 9));
         default: d = 10'($urandom());
      endcase
      return {d, 22'($urandom())};
   endfunction

   initial begin
      walk_result_type tr;
      int r;
      logic [7:0] fi;
      root_frame = '0;
      ram_base = 32'h8000_0000;
      first_frame = 9'd64;
      foreach (frame_busy[i]) frame_busy[i] = 1'b0;

      add_row(tlpm_pkg::OP_TRANSLATE, 32'h0, 32'h0, 8'h0, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_NO_TABLE);
      add_row(tlpm_pkg::OP_TRANSLATE, 32'hffff_ffff, 32'h0, 8'h0, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_NO_TABLE);
      add_row(tlpm_pkg::OP_UNMAP, 32'h0, 32'h0, 8'h0, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_NO_TABLE);
      add_row(3'd5, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(3'd6, 32'h0, 32'h0, 8'h0, 1, 32'h0, 8'h0, tlpm_pkg::ST_OK);
      add_row(3'd7, 32'h1234_5678, 32'h0, 8'h0, 1, 32'h0, 8'h0, tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_ALLOC, 32'h0, 32'h0, 8'h0, 1, 32'h0, 8'd64,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_FREE, 32'h0, 32'h0, 8'd64, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_FREE, 32'h0, 32'h0, 8'hff, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_MAP, 32'h0040_0123, 32'hffff_ffff, 8'h0, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_TRANSLATE, 32'h0040_0abc, 32'h0, 8'h0, 1, 32'hffff_fabc,
              8'h0, tlpm_pkg::ST_OK);
      // entry already set: map leaves it alone
      add_row(tlpm_pkg::OP_MAP, 32'h0040_0000, 32'h0, 8'h0, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_TRANSLATE, 32'h0040_0abc, 32'h0, 8'h0, 1, 32'hffff_fabc,
              8'h0, tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_UNMAP, 32'h0040_0000, 32'h0, 8'h0, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      // table present, entry empty: offset only
      add_row(tlpm_pkg::OP_TRANSLATE, 32'h0040_0abc, 32'h0, 8'h0, 1, 32'h0000_0abc,
              8'h0, tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_MAP, 32'hffff_ffff, 32'h1234_5000, 8'h0, 1, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_TRANSLATE, 32'hffff_ffff, 32'h0, 8'h0, 1, 32'h1234_5fff,
              8'h0, tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_ALLOC, 32'h0, 32'h0, 8'h0, 0, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_MAP, 32'h0080_1000, 32'h0, 8'h0, 0, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);
      add_row(tlpm_pkg::OP_TRANSLATE, 32'h0080_1fff, 32'h0, 8'h0, 0, 32'h0, 8'h0,
              tlpm_pkg::ST_OK);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         tr = '{rows[i].phys, rows[i].fnum, rows[i].status};
         send(rows[i].op, rows[i].va, rows[i].pa, rows[i].fi, rows[i].typed, tr);
      end
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               write_csr(tlpm_pkg::CSR_FIRST, {23'($urandom()), 9'd256});
               write_csr(tlpm_pkg::CSR_BASE, 32'hffff_ffff);
               write_csr(tlpm_pkg::CSR_ROOT, 32'hffff_ff00 | 32'd255);
            end
            1: begin
               write_csr(tlpm_pkg::CSR_FIRST, 32'd0);
               write_csr(tlpm_pkg::CSR_BASE, 32'h0);
               write_csr(tlpm_pkg::CSR_ROOT, 32'd0);
               write_csr(2'd3, $urandom());
            end
            2: begin
               write_csr(tlpm_pkg::CSR_ROOT, 32'd3);
               write_csr(tlpm_pkg::CSR_BASE, 32'h8000_0000);
               write_csr(tlpm_pkg::CSR_FIRST, 32'd64);
            end
            3: begin
               // unaligned base: a fresh table lands in the frame below the one taken
               write_csr(tlpm_pkg::CSR_BASE,
                         32'h8000_0000 | 32'($urandom_range(1, 4095)));
               write_csr(tlpm_pkg::CSR_FIRST, 32'd200);
            end
            4: begin
               write_csr(tlpm_pkg::CSR_BASE, {$urandom_range(0, 15) << 28} | 32'h0);
               write_csr(tlpm_pkg::CSR_ROOT, $urandom_range(0, 31));
               write_csr(tlpm_pkg::CSR_FIRST, 32'd32 + $urandom_range(0, 32));
            end
            5: begin
               write_csr(tlpm_pkg::CSR_BASE, 32'hffff_f000);
               write_csr(tlpm_pkg::CSR_ROOT, 32'd1);
               write_csr(tlpm_pkg::CSR_FIRST, 32'd255);
            end
            default: begin
               write_csr(tlpm_pkg::CSR_BASE, 32'h8000_0000);
               write_csr(tlpm_pkg::CSR_ROOT, 32'd0);
               write_csr(tlpm_pkg::CSR_FIRST, 32'd64);
            end
         endcase
         va_pool.delete();
         for (int n = 0; n < 200; n++) begin
            no_gaps = (n >= 80 && n < 120);
            if (n == 150) drain();
            r = $urandom_range(0, 99);
            if (r < 28) begin
               va_pool.push_back(fresh_va());
               if (va_pool.size() > 16) void'(va_pool.pop_front());
               send_rand(tlpm_pkg::OP_MAP, va_pool[$], $urandom(), 8'($urandom()));
            end else if (r < 48)
               send_rand(tlpm_pkg::OP_TRANSLATE, pool_va(), $urandom(),
                         8'($urandom()));
            else if (r < 58)
               send_rand(tlpm_pkg::OP_UNMAP, pool_va(), $urandom(), 8'($urandom()));
            else if (r < 72)
               send_rand(tlpm_pkg::OP_ALLOC, $urandom(), $urandom(), 8'($urandom()));
            else if (r < 88) begin
               fi = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                : 8'($urandom_range(0, 127));
               send_rand(tlpm_pkg::OP_FREE, $urandom(), $urandom(), fi);
            end else if (r < 95)
               send_rand(tlpm_pkg::OP_TRANSLATE, $urandom(), $urandom(),
                         8'($urandom()));
            else
               send_rand(3'($urandom_range(5, 7)), $urandom(), $urandom(),
                         8'($urandom()));
         end
         no_gaps = 1'b0;
         drain();
      end

      repeat (20) @(posedge clock);
      if (!failed && walk_q.size() == 0)
         $display("[two_level_page_map_with_frame_bitmap_core] OK");
      else
         $display("[two_level_page_map_with_frame_bitmap_core] ERROR");
      $finish;
   end
endmodule
